/* design/tak_pkg.sv */
// ----------------------------------------------------------------------------
// tak_pkg
// shared types, constants and tables of the trend angle kernel smoother
// ----------------------------------------------------------------------------
`default_nettype none

package tak_pkg;

  localparam int MaxWindow   = 64;
  localparam int PtrBits     = 6;
  localparam int PriceBits   = 32;
  localparam int CordicSteps = 26;
  localparam int DivBits     = 56;

  localparam logic [15:0] ANGLE_MAX   = 16'd23040;
  localparam logic [29:0] DEG_Q8_MUL  = 30'd961261421;

  localparam logic [1:0] REG_WINDOW_LENGTH     = 2'd0;
  localparam logic [1:0] REG_SCALE_DIVISOR     = 2'd1;
  localparam logic [1:0] REG_INVERSE_BANDWIDTH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDCLOSE, ST_DIFF, ST_QDIV, ST_MUL, ST_ANGLE, ST_CORDIC,
    ST_KSETUP, ST_KJJ, ST_KU, ST_KW, ST_KACC, ST_MEAN, ST_MDIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    COR_IDLE, COR_NORM, COR_ITER, COR_CONV
  } cor_state_t;

  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] num;
    logic [DivBits-1:0] den;
    logic [3:0]         steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] k);
    logic [29:0] v;
    case (k)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/tak_div.sv */
// ----------------------------------------------------------------------------
// tak_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tak_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tak_pkg::div_req_t req,
  output tak_pkg::div_rsp_t      rsp
);

  logic [tak_pkg::DivBits-1:0] rem_r, rem_nxt;
  logic [tak_pkg::DivBits-1:0] den_r, den_nxt;
  logic [15:0]                 quot_r, quot_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.num;
      den_nxt  = req.den;
      quot_nxt = '0;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= den_r) begin
        rem_nxt  = rem_r - den_r;
        quot_nxt = {quot_r[14:0], 1'b1};
      end else begin
        quot_nxt = {quot_r[14:0], 1'b0};
      end
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

/* design/tak_cordic.sv */
// ----------------------------------------------------------------------------
// tak_cordic
// vectoring cordic with normalize and degree conversion, one step per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tak_cordic (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [38:0] num,
  input  wire logic [38:0] den,
  output logic             done,
  output logic [14:0]      deg
);

  tak_pkg::cor_state_t state_r, state_nxt;
  logic [63:0]        x_r, x_nxt;
  logic [63:0]        y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [4:0]         k_r, k_nxt;
  logic [61:0]        prod_r, prod_nxt;
  logic               conv_r, conv_nxt;
  logic               done_r, done_nxt;
  logic [14:0]        deg_r, deg_nxt;
  logic [63:0]        ys, xs, orv;
  logic [62:0]        rnd;
  logic [31:0]        zc;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    k_nxt     = k_r;
    prod_nxt  = prod_r;
    conv_nxt  = conv_r;
    done_nxt  = 1'b0;
    deg_nxt   = deg_r;
    orv       = x_r | y_r;
    ys        = 64'($signed(y_r) >>> k_r);
    xs        = x_r >> k_r;
    zc        = z_r[32] ? 32'd0 : z_r[31:0];
    rnd       = {1'b0, prod_r} + (63'd1 << 45);
    case (state_r)
      tak_pkg::COR_IDLE: begin
        if (start) begin
          x_nxt     = {25'd0, den};
          y_nxt     = {25'd0, num};
          z_nxt     = '0;
          k_nxt     = '0;
          state_nxt = tak_pkg::COR_NORM;
        end
      end
      tak_pkg::COR_NORM: begin
        if (orv[63:51] == '0) begin
          x_nxt = x_r << 8;
          y_nxt = y_r << 8;
        end else if (orv[63:58] == '0) begin
          x_nxt = x_r << 1;
          y_nxt = y_r << 1;
        end else begin
          state_nxt = tak_pkg::COR_ITER;
        end
      end
      tak_pkg::COR_ITER: begin
        if (!y_r[63]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + $signed({3'd0, tak_pkg::atan_q30(k_r)});
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - $signed({3'd0, tak_pkg::atan_q30(k_r)});
        end
        k_nxt = k_r + 5'd1;
        if (k_r == 5'(tak_pkg::CordicSteps - 1)) begin
          state_nxt = tak_pkg::COR_CONV;
          conv_nxt  = 1'b0;
        end
      end
      tak_pkg::COR_CONV: begin
        if (!conv_r) begin
          prod_nxt = 62'(zc * tak_pkg::DEG_Q8_MUL);
          conv_nxt = 1'b1;
        end else begin
          if (rnd[62:46] > {1'b0, tak_pkg::ANGLE_MAX}) begin
            deg_nxt = tak_pkg::ANGLE_MAX[14:0];
          end else begin
            deg_nxt = rnd[60:46];
          end
          done_nxt  = 1'b1;
          state_nxt = tak_pkg::COR_IDLE;
        end
      end
      default: state_nxt = tak_pkg::COR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tak_pkg::COR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    k_r    <= k_nxt;
    prod_r <= prod_nxt;
    conv_r <= conv_nxt;
    deg_r  <= deg_nxt;
  end

  assign done = done_r;
  assign deg  = deg_r;

endmodule

`default_nettype wire

/* design/trend_angle_kernel_smoother.sv */
// ----------------------------------------------------------------------------
// trend_angle_kernel_smoother
// trend angle of price bars with epanechnikov kernel smoothing of past angles
// ----------------------------------------------------------------------------
// an item skips the angle path up to bar L, else takes it through the divider,
// normalize, cordic and convert steps, or a short way with a zero divisor, no price
// change or a zero window over scale quotient; from bar 2L+2 on the kernel taps and
// the mean divide follow; the next item is taken after the last ends
// a result waits in an output register while the next item is worked on
// reset is synchronous, active low; the history rings need no clearing
`default_nettype none

module trend_angle_kernel_smoother (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_new_series,
  input  wire logic [31:0]        in_close_price,
  input  wire logic [31:0]        in_range_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_raw_angle,
  output logic signed [15:0]      out_smoothed_angle,
  output logic                    out_divisor_zero,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  localparam int PB = tak_pkg::PtrBits;

  tak_pkg::state_t state_r, state_nxt;

  logic [6:0]  wl_r, sd_r;
  logic [23:0] ib_r;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [PB-1:0] wp_r, wp_nxt;

  logic [31:0] close_r, close_nxt, range_r, range_nxt;
  logic [6:0]  len_r, len_nxt, scl_r, scl_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [PB-1:0] slot_r, slot_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt, zd_r, zd_nxt;
  logic [6:0]  q_r, q_nxt;
  logic [38:0] n_r, n_nxt, d_r, d_nxt;
  logic signed [15:0] raw_r, raw_nxt, smooth_r, smooth_nxt;
  logic        flag_r, flag_nxt, prod_r, prod_nxt;
  logic [PB-1:0] j_r, j_nxt;
  logic [11:0] jj_r, jj_nxt;
  logic [35:0] u_r, u_nxt;
  logic [32:0] w_r, w_nxt;
  logic        wv_r, wv_nxt;
  logic signed [53:0] saw_r, saw_nxt;
  logic [38:0] sw_r, sw_nxt;
  logic        sneg_r, sneg_nxt;

  logic        ov_r, ov_nxt;
  logic signed [15:0] oraw_r, oraw_nxt, osm_r, osm_nxt;
  logic        oflag_r, oflag_nxt;

  logic [31:0] close_mem [tak_pkg::MaxWindow];
  logic [15:0] angle_mem [tak_pkg::MaxWindow];
  logic [31:0] close_rd_r;
  logic [15:0] angle_rd_r;
  logic [PB-1:0] close_ra, angle_ra;
  logic        mem_we;

  tak_pkg::div_req_t div_req;
  tak_pkg::div_rsp_t div_rsp;
  logic        cor_start, cor_done;
  logic [14:0] cor_deg;

  logic [32:0] diff;
  logic [6:0]  len_in;
  logic [52:0] mabs;
  logic signed [49:0] aw;

  tak_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  tak_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cor_start),
    .num  (n_r),
    .den  (d_r),
    .done (cor_done),
    .deg  (cor_deg)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= 7'd8;
      sd_r <= 7'd2;
      ib_r <= 24'd16384;
    end else if (cfg_valid) begin
      case (cfg_index)
        tak_pkg::REG_WINDOW_LENGTH:     wl_r <= cfg_data[6:0];
        tak_pkg::REG_SCALE_DIVISOR:     sd_r <= cfg_data[6:0];
        tak_pkg::REG_INVERSE_BANDWIDTH: ib_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      close_mem[slot_r] <= close_r;
    end
    close_rd_r <= close_mem[close_ra];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      angle_mem[slot_r] <= raw_r;
    end
    angle_rd_r <= angle_mem[angle_ra];
  end

  always_comb begin
    if (wl_r == 7'd0) begin
      len_in = 7'd1;
    end else if (wl_r > 7'(tak_pkg::MaxWindow)) begin
      len_in = 7'(tak_pkg::MaxWindow);
    end else begin
      len_in = wl_r;
    end
  end

  assign close_ra = slot_r - len_r[PB-1:0];
  assign angle_ra = slot_r - len_r[PB-1:0] + j_r;
  assign diff     = {1'b0, close_r} - {1'b0, close_rd_r};
  assign mabs     = saw_r[53] ? 53'(-saw_r) : saw_r[52:0];
  assign aw       = $signed(angle_rd_r) * $signed({1'b0, w_r});

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    wp_nxt     = wp_r;
    close_nxt  = close_r;
    range_nxt  = range_r;
    len_nxt    = len_r;
    scl_nxt    = scl_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    zd_nxt     = zd_r;
    q_nxt      = q_r;
    n_nxt      = n_r;
    d_nxt      = d_r;
    raw_nxt    = raw_r;
    smooth_nxt = smooth_r;
    flag_nxt   = flag_r;
    prod_nxt   = prod_r;
    j_nxt      = j_r;
    jj_nxt     = jj_r;
    u_nxt      = u_r;
    w_nxt      = w_r;
    wv_nxt     = wv_r;
    saw_nxt    = saw_r;
    sw_nxt     = sw_r;
    sneg_nxt   = sneg_r;
    ov_nxt     = ov_r & ~out_ready;
    oraw_nxt   = oraw_r;
    osm_nxt    = osm_r;
    oflag_nxt  = oflag_r;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    cor_start  = 1'b0;
    div_req    = '0;
    case (state_r)
      tak_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          close_nxt = in_close_price;
          range_nxt = in_range_value;
          len_nxt   = len_in;
          scl_nxt   = (sd_r == 7'd0) ? 7'd1 : sd_r;
          idx_nxt   = in_new_series ? 8'd0 : cnt_r;
          slot_nxt  = in_new_series ? '0 : wp_r;
          raw_nxt   = '0;
          flag_nxt  = 1'b0;
          smooth_nxt = '0;
          state_nxt = tak_pkg::ST_RDCLOSE;
        end
      end
      tak_pkg::ST_RDCLOSE: state_nxt = tak_pkg::ST_DIFF;
      tak_pkg::ST_DIFF: begin
        neg_nxt = diff[32];
        mag_nxt = diff[32] ? 32'(-diff) : diff[31:0];
        zd_nxt  = (diff == '0);
        if (idx_r < {1'b0, len_r}) begin
          state_nxt = tak_pkg::ST_KSETUP;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = tak_pkg::DivBits'(len_r);
          div_req.den   = tak_pkg::DivBits'(scl_r) << 6;
          div_req.steps = 4'd7;
          state_nxt     = tak_pkg::ST_QDIV;
        end
      end
      tak_pkg::ST_QDIV: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quot[6:0];
          state_nxt = tak_pkg::ST_MUL;
        end
      end
      tak_pkg::ST_MUL: begin
        n_nxt     = 39'(mag_r * q_r);
        d_nxt     = 39'(range_r * len_r);
        state_nxt = tak_pkg::ST_ANGLE;
      end
      tak_pkg::ST_ANGLE: begin
        if (d_r == '0) begin
          flag_nxt  = 1'b1;
          raw_nxt   = zd_r ? 16'sd0 : (neg_r ? -$signed(tak_pkg::ANGLE_MAX)
                                             : $signed(tak_pkg::ANGLE_MAX));
          state_nxt = tak_pkg::ST_KSETUP;
        end else if (n_r == '0) begin
          raw_nxt   = '0;
          state_nxt = tak_pkg::ST_KSETUP;
        end else begin
          cor_start = 1'b1;
          state_nxt = tak_pkg::ST_CORDIC;
        end
      end
      tak_pkg::ST_CORDIC: begin
        if (cor_done) begin
          raw_nxt   = neg_r ? -$signed({1'b0, cor_deg}) : $signed({1'b0, cor_deg});
          state_nxt = tak_pkg::ST_KSETUP;
        end
      end
      tak_pkg::ST_KSETUP: begin
        saw_nxt = '0;
        sw_nxt  = '0;
        j_nxt   = PB'(len_r - 7'd1);
        if (idx_r > {len_r, 1'b0}) begin
          prod_nxt  = 1'b1;
          state_nxt = (len_r == 7'd1) ? tak_pkg::ST_MEAN : tak_pkg::ST_KJJ;
        end else begin
          prod_nxt  = 1'b0;
          state_nxt = tak_pkg::ST_DONE;
        end
      end
      tak_pkg::ST_KJJ: begin
        jj_nxt    = 12'(j_r * j_r);
        state_nxt = tak_pkg::ST_KU;
      end
      tak_pkg::ST_KU: begin
        u_nxt     = 36'(jj_r * ib_r);
        state_nxt = tak_pkg::ST_KW;
      end
      tak_pkg::ST_KW: begin
        wv_nxt    = (u_r < 36'd65536);
        w_nxt     = 33'(34'h1_0000_0000 - 34'(u_r[15:0] * u_r[15:0]));
        state_nxt = tak_pkg::ST_KACC;
      end
      tak_pkg::ST_KACC: begin
        if (wv_r) begin
          saw_nxt = saw_r + 54'(aw);
          sw_nxt  = sw_r + 39'(w_r);
        end
        if (j_r == PB'(1)) begin
          state_nxt = tak_pkg::ST_MEAN;
        end else begin
          j_nxt     = j_r - PB'(1);
          state_nxt = tak_pkg::ST_KJJ;
        end
      end
      tak_pkg::ST_MEAN: begin
        sneg_nxt = saw_r[53];
        if (sw_r == '0) begin
          smooth_nxt = '0;
          state_nxt  = tak_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = tak_pkg::DivBits'(mabs) + tak_pkg::DivBits'(sw_r >> 1);
          div_req.den   = tak_pkg::DivBits'(sw_r) << 14;
          div_req.steps = 4'd15;
          state_nxt     = tak_pkg::ST_MDIV;
        end
      end
      tak_pkg::ST_MDIV: begin
        if (div_rsp.done) begin
          smooth_nxt = sneg_r ? -$signed({1'b0, div_rsp.quot[14:0]})
                              : $signed({1'b0, div_rsp.quot[14:0]});
          state_nxt  = tak_pkg::ST_DONE;
        end
      end
      tak_pkg::ST_DONE: begin
        if (!(prod_r && ov_r && !out_ready)) begin
          mem_we = 1'b1;
          wp_nxt = slot_r + PB'(1);
          if (idx_r != 8'd255) begin
            cnt_nxt = idx_r + 8'd1;
          end else begin
            cnt_nxt = idx_r;
          end
          if (prod_r) begin
            ov_nxt    = 1'b1;
            oraw_nxt  = raw_r;
            osm_nxt   = smooth_r;
            oflag_nxt = flag_r;
          end
          state_nxt = tak_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tak_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tak_pkg::ST_IDLE;
      cnt_r   <= '0;
      wp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wp_r    <= wp_nxt;
      ov_r    <= ov_nxt;
    end
    close_r  <= close_nxt;
    range_r  <= range_nxt;
    len_r    <= len_nxt;
    scl_r    <= scl_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    zd_r     <= zd_nxt;
    q_r      <= q_nxt;
    n_r      <= n_nxt;
    d_r      <= d_nxt;
    raw_r    <= raw_nxt;
    smooth_r <= smooth_nxt;
    flag_r   <= flag_nxt;
    prod_r   <= prod_nxt;
    j_r      <= j_nxt;
    jj_r     <= jj_nxt;
    u_r      <= u_nxt;
    w_r      <= w_nxt;
    wv_r     <= wv_nxt;
    saw_r    <= saw_nxt;
    sw_r     <= sw_nxt;
    sneg_r   <= sneg_nxt;
    oraw_r   <= oraw_nxt;
    osm_r    <= osm_nxt;
    oflag_r  <= oflag_nxt;
  end

  assign out_valid          = ov_r;
  assign out_raw_angle      = oraw_r;
  assign out_smoothed_angle = osm_r;
  assign out_divisor_zero   = oflag_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tak_pkg::ST_IDLE |-> !div_rsp.done && !cor_done)
    else $error("unit finished with no item in work");

  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_raw_angle <= 16'sd23040 && out_raw_angle >= -16'sd23040))
    else $error("raw angle out of range");

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the trend angle kernel smoother: a directed table of
// price bars, then random phases of register settings and price series, each result
// checked field by field against a table value or a behavioral prediction of the block
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] raw;
    logic signed [15:0] smooth;
    logic               dz;
  } angle_res_t;

  typedef struct {
    logic        ns;
    logic [31:0] close;
    logic [31:0] range;
    logic        has_exp;
    logic signed [15:0] raw;
    logic signed [15:0] smooth;
    logic        dz;
  } bar_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_new_series;
  logic [31:0] in_close_price, in_range_value;
  logic out_valid, out_ready;
  logic signed [15:0] out_raw_angle, out_smoothed_angle;
  logic out_divisor_zero;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  trend_angle_kernel_smoother u_top (.*);

  // shadow configuration and history
  logic [6:0]  win_len;
  logic [6:0]  scale_div;
  logic [23:0] inv_bw;
  logic [31:0] close_ring [tak_pkg::MaxWindow];
  int          angle_ring [tak_pkg::MaxWindow];
  int unsigned bar_cnt, wr_ptr;

  angle_res_t  pending_angles [$];
  int          errors;
  bit          quiet, hold_req;
  logic [31:0] last_close;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint atan_tab(int k);
    longint t [tak_pkg::CordicSteps] = '{843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    return t[k];
  endfunction

  function automatic int cordic_angle(logic [63:0] n, logic [63:0] d);
    logic [63:0] x, y, ys, xs, deg;
    longint z;
    z = 0;
    if (n == 0) return 0;
    while (((n | d) >> 58) == 0) begin
      n = n << 1;
      d = d << 1;
    end
    x = d;
    y = n;
    for (int k = 0; k < tak_pkg::CordicSteps; k++) begin
      ys = $signed(y) >>> k;
      xs = x >> k;
      if (!y[63]) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_tab(k));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_tab(k));
      end
    end
    if (z < 0) z = 0;
    deg = (64'(z) * 64'd961261421 + (64'd1 << 45)) >> 46;
    if (deg > 64'd23040) deg = 64'd23040;
    return int'(deg);
  endfunction

  // advance the shadow state by one bar, returns 1 when a result is due
  function automatic bit predict_bar(logic ns, logic [31:0] close, logic [31:0] range,
                                     output angle_res_t res);
    int unsigned len, scl, idx, slot, bslot, s;
    longint diff, sum_aw;
    logic [63:0] mag, q, d, u, w, sum_w, m, r;
    int raw, sm;
    bit flag, due;
    len = win_len;
    scl = (scale_div == 0) ? 1 : scale_div;
    raw = 0;
    sm = 0;
    flag = 0;
    due = 0;
    if (len < 1) len = 1;
    if (len > tak_pkg::MaxWindow) len = tak_pkg::MaxWindow;
    if (ns) begin
      bar_cnt = 0;
      wr_ptr = 0;
    end
    idx = bar_cnt;
    slot = wr_ptr % tak_pkg::MaxWindow;
    bslot = (slot + tak_pkg::MaxWindow - len) % tak_pkg::MaxWindow;
    if (idx >= len) begin
      diff = longint'(close) - longint'(close_ring[bslot]);
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      q = len / scl;
      d = 64'(range) * len;
      if (d == 0) begin
        flag = 1;
        raw = (diff == 0) ? 0 : 23040;
      end else begin
        raw = cordic_angle(mag * q, d);
      end
      if (diff < 0) raw = -raw;
    end
    if (idx > 2 * len) begin
      sum_aw = 0;
      sum_w = 0;
      for (int j = len - 1; j >= 1; j--) begin
        u = 64'(j) * 64'(j) * 64'(inv_bw);
        if (u < 64'd65536) begin
          w = (64'd1 << 32) - u * u;
          s = (slot + tak_pkg::MaxWindow - (len - j)) % tak_pkg::MaxWindow;
          sum_aw = sum_aw + longint'(angle_ring[s]) * longint'(w);
          sum_w = sum_w + w;
        end
      end
      if (sum_w > 0) begin
        m = (sum_aw < 0) ? 64'(-sum_aw) : 64'(sum_aw);
        r = (m + sum_w / 2) / sum_w;
        sm = (sum_aw < 0) ? -int'(r) : int'(r);
      end
      res.raw = 16'(raw);
      res.smooth = 16'(sm);
      res.dz = flag;
      due = 1;
    end
    close_ring[slot] = close;
    angle_ring[slot] = raw;
    wr_ptr = (slot + 1) % tak_pkg::MaxWindow;
    if (bar_cnt < 255) bar_cnt = idx + 1;
    return due;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tak_pkg::REG_WINDOW_LENGTH:     win_len = val[6:0];
      tak_pkg::REG_SCALE_DIVISOR:     scale_div = val[6:0];
      tak_pkg::REG_INVERSE_BANDWIDTH: inv_bw = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_bar(bar_row_t b);
    angle_res_t res;
    in_valid <= 1'b1;
    in_new_series <= b.ns;
    in_close_price <= b.close;
    in_range_value <= b.range;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_bar(b.ns, b.close, b.range, res)) begin
      if (b.has_exp) begin
        res.raw = b.raw;
        res.smooth = b.smooth;
        res.dz = b.dz;
      end
      pending_angles.push_back(res);
    end
    if (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic bar_row_t random_bar(logic ns);
    bar_row_t b;
    int unsigned sel;
    b.ns = ns;
    b.has_exp = 0;
    sel = $urandom_range(99);
    if (sel < 8) b.close = $urandom;
    else b.close = last_close + 32'($signed($urandom_range(0, 4000)) - 2000);
    last_close = b.close;
    sel = $urandom_range(99);
    if (sel < 5) b.range = 0;
    else if (sel < 12) b.range = $urandom;
    else b.range = $urandom_range(1, 6000);
    return b;
  endfunction

  // receiver side
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (4000) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 16);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        $display("%0t unexpected item raw %0d smooth %0d dz %0b", $time,
                 out_raw_angle, out_smoothed_angle, out_divisor_zero);
        errors++;
      end else begin
        angle_res_t e;
        e = pending_angles.pop_front();
        if (out_raw_angle !== e.raw) begin
          $display("%0t raw_angle expected %0d got %0d", $time, e.raw, out_raw_angle);
          errors++;
        end
        if (out_smoothed_angle !== e.smooth) begin
          $display("%0t smoothed_angle expected %0d got %0d", $time, e.smooth,
                   out_smoothed_angle);
          errors++;
        end
        if (out_divisor_zero !== e.dz) begin
          $display("%0t divisor_zero expected %0b got %0b", $time, e.dz, out_divisor_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    bar_row_t dir_tab [14];
    logic [6:0] len_pick [10];
    logic [6:0] scl_pick [6];
    logic [23:0] bw_pick [6];
    int items, phase, leff, n;
    logic [23:0] v;
    len_pick = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd8, 7'd16, 7'd64, 7'd65, 7'd127};
    scl_pick = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd3};
    bw_pick = '{24'd0, 24'd1, 24'd16384, 24'hffffff, 24'd300, 24'd2000};
    errors = 0;
    quiet = 0;
    hold_req = 0;
    win_len = 7'd8;
    scale_div = 7'd2;
    inv_bw = 24'd16384;
    bar_cnt = 0;
    wr_ptr = 0;
    last_close = 32'd1000000;
    foreach (close_ring[i]) begin
      close_ring[i] = 0;
      angle_ring[i] = 0;
    end
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_new_series <= 1'b0;
    in_close_price <= '0;
    in_range_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of one: the kernel is empty, so the smoothed angle is zero
    write_reg(tak_pkg::REG_WINDOW_LENGTH, 24'd1);
    write_reg(tak_pkg::REG_SCALE_DIVISOR, 24'd1);
    write_reg(2'd3, 24'habcdef);
    dir_tab[0]  = '{1, 32'd100, 32'd5, 0, 0, 0, 0};
    dir_tab[1]  = '{0, 32'd200, 32'd5, 0, 0, 0, 0};
    dir_tab[2]  = '{0, 32'd300, 32'd0, 0, 0, 0, 0};
    dir_tab[3]  = '{0, 32'd400, 32'd0, 1, 16'sd23040, 0, 1};
    dir_tab[4]  = '{0, 32'd300, 32'd0, 1, -16'sd23040, 0, 1};
    dir_tab[5]  = '{0, 32'd300, 32'd0, 1, 0, 0, 1};
    dir_tab[6]  = '{0, 32'd300, 32'd7, 1, 0, 0, 0};
    dir_tab[7]  = '{0, 32'hffffffff, 32'd0, 1, 16'sd23040, 0, 1};
    dir_tab[8]  = '{0, 32'd0, 32'd0, 1, -16'sd23040, 0, 1};
    dir_tab[9]  = '{0, 32'd0, 32'hffffffff, 0, 0, 0, 0};
    dir_tab[10] = '{0, 32'hffffffff, 32'd1, 0, 0, 0, 0};
    dir_tab[11] = '{0, 32'd0, 32'd1, 0, 0, 0, 0};
    dir_tab[12] = '{1, 32'h5555aaaa, 32'haaaa5555, 0, 0, 0, 0};
    dir_tab[13] = '{0, 32'haaaa5555, 32'h5555aaaa, 0, 0, 0, 0};
    foreach (dir_tab[i]) send_bar(dir_tab[i]);
    items = 14;

    phase = 0;
    while (items < 1700) begin
      drain_idle();
      if (phase < 10) v = 24'(len_pick[phase]);
      else if ($urandom_range(9) == 0) v = 24'(len_pick[$urandom_range(9)]);
      else v = 24'($urandom_range(2, 16) | ($urandom & 32'hffff80));
      write_reg(tak_pkg::REG_WINDOW_LENGTH, v);
      if (phase < 6) v = 24'(scl_pick[phase]);
      else v = 24'($urandom_range(1, 8) | ($urandom & 32'hffff80));
      write_reg(tak_pkg::REG_SCALE_DIVISOR, v);
      if (phase < 6) v = bw_pick[phase];
      else v = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20000));
      write_reg(tak_pkg::REG_INVERSE_BANDWIDTH, v);
      leff = (win_len == 0) ? 1 : ((win_len > tak_pkg::MaxWindow) ? tak_pkg::MaxWindow
                                                                  : win_len);
      n = 2 * leff + 1 + $urandom_range(15, 50);
      quiet = (phase == 4);
      if (phase == 7) hold_req = 1;
      for (int i = 0; i < n; i++) begin
        if (phase == 8 && i == n / 2) drain_idle();
        send_bar(random_bar(i == 0 || $urandom_range(199) == 0));
        items++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    quiet = 1;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0 && pending_angles.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* trend_angle_kernel_smoother.f */
design/tak_pkg.sv
design/tak_div.sv
design/tak_cordic.sv
design/trend_angle_kernel_smoother.sv
sim/tb.sv
